// ===== src/elt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elt_pkg: shared types and constants of the expression tokenizer
// Token kind codes, character classes, keyword patterns and the token record.
// ----------------------------------------------------------------------------
package elt_pkg;

  // Default width of the internal byte offset counters
  localparam int OffsetBitsDef = 16;

  // Depth of the token queue in front of the output port
  localparam int QueueDepth = 4;

  // Saturation value of reported start and length fields
  localparam logic [15:0] FieldMax = 16'hFFFF;

  // Token kinds
  localparam logic [4:0] KIND_END    = 5'd0;
  localparam logic [4:0] KIND_ERROR  = 5'd1;
  localparam logic [4:0] KIND_IDENT  = 5'd2;
  localparam logic [4:0] KIND_NUMBER = 5'd3;
  localparam logic [4:0] KIND_IF     = 5'd4;
  localparam logic [4:0] KIND_WHILE  = 5'd5;
  localparam logic [4:0] KIND_LOOP   = 5'd6;
  localparam logic [4:0] KIND_PRINT  = 5'd7;
  localparam logic [4:0] KIND_LPAREN = 5'd8;
  localparam logic [4:0] KIND_RPAREN = 5'd9;
  localparam logic [4:0] KIND_LBRACE = 5'd10;
  localparam logic [4:0] KIND_RBRACE = 5'd11;
  localparam logic [4:0] KIND_PLUS   = 5'd12;
  localparam logic [4:0] KIND_MINUS  = 5'd14;
  localparam logic [4:0] KIND_STAR   = 5'd16;
  localparam logic [4:0] KIND_SLASH  = 5'd18;
  localparam logic [4:0] KIND_LT     = 5'd20;
  localparam logic [4:0] KIND_GT     = 5'd22;
  localparam logic [4:0] KIND_ASSIGN = 5'd24;
  localparam logic [4:0] KIND_BANG   = 5'd26;
  localparam logic [4:0] KIND_SEMI   = 5'd28;
  localparam logic [4:0] KIND_NONE   = 5'd0;  // no operator for this byte

  // Keyword patterns, last character in the lowest byte
  localparam logic [39:0] KwIf    = 40'h00_0000_6966;
  localparam logic [39:0] KwWhile = 40'h77_6869_6C65;
  localparam logic [39:0] KwLoop  = 40'h00_6C6F_6F70;
  localparam logic [39:0] KwPrint = 40'h70_7269_6E74;

  // One output token
  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        last;
  } tok_t;

  // Tokens produced by one accepted byte
  typedef struct packed {
    logic [1:0] cnt;
    tok_t       r0;
    tok_t       r1;
  } push_t;

  function automatic logic is_letter(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  // Base kind of a single-character operator, KIND_NONE otherwise
  function automatic logic [4:0] oper_base(input logic [7:0] b);
    logic [4:0] k;
    case (b)
      8'h2B:   k = KIND_PLUS;
      8'h2D:   k = KIND_MINUS;
      8'h2A:   k = KIND_STAR;
      8'h2F:   k = KIND_SLASH;
      8'h3C:   k = KIND_LT;
      8'h3E:   k = KIND_GT;
      8'h3D:   k = KIND_ASSIGN;
      8'h21:   k = KIND_BANG;
      default: k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

// ===== src/elt_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elt_scan: scanner state and per-byte token logic
// Holds the lexer state and, for each accepted byte, produces up to two
// tokens (a flushed pending token first, then the byte's own token).
// ----------------------------------------------------------------------------
module elt_scan
  import elt_pkg::*;
#(
  parameter int OFFSET_BITS = OffsetBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       acc_i,   // byte accepted this cycle
  input  logic [7:0] byte_i,
  output push_t      push_o
);

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_COMMENT = 3'd1;
  localparam logic [2:0] MODE_IDENT   = 3'd2;
  localparam logic [2:0] MODE_NUMBER  = 3'd3;
  localparam logic [2:0] MODE_OPER    = 3'd4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_RBRC  = 8'h7D;

  logic [2:0]             mode_q, mode_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] begin_q, begin_d;
  logic [39:0]            prefix_q, prefix_d;
  logic [4:0]             oper_q, oper_d;
  logic                   dot_q, dot_d;
  logic [15:0]            run_q, run_d;

  logic [15:0] pos_rep, begin_rep, run_inc;
  logic [31:0] pos_ext, begin_ext;
  logic [4:0]  op, word_kind;
  logic        consumed, flush_v, own_v;
  tok_t        flush_t, own_t;

  // Clamp offsets to the 16-bit report fields
  assign pos_ext   = 32'(pos_q);
  assign begin_ext = 32'(begin_q);
  assign pos_rep   = (pos_ext > 32'(FieldMax)) ? FieldMax : pos_ext[15:0];
  assign begin_rep = (begin_ext > 32'(FieldMax)) ? FieldMax : begin_ext[15:0];
  assign run_inc   = (run_q != FieldMax) ? run_q + 16'd1 : run_q;
  assign op        = oper_base(byte_i);

  // Keyword match on the pending identifier
  always_comb begin
    if ((run_q == 16'd2) && (prefix_q == KwIf)) begin
      word_kind = KIND_IF;
    end else if ((run_q == 16'd5) && (prefix_q == KwWhile)) begin
      word_kind = KIND_WHILE;
    end else if ((run_q == 16'd4) && (prefix_q == KwLoop)) begin
      word_kind = KIND_LOOP;
    end else if ((run_q == 16'd5) && (prefix_q == KwPrint)) begin
      word_kind = KIND_PRINT;
    end else begin
      word_kind = KIND_IDENT;
    end
  end

  // Per-byte scan: continue or flush the pending token, then classify
  always_comb begin
    mode_d   = mode_q;
    begin_d  = begin_q;
    prefix_d = prefix_q;
    oper_d   = oper_q;
    dot_d    = dot_q;
    run_d    = run_q;
    pos_d    = (pos_q != {OFFSET_BITS{1'b1}}) ? pos_q + OFFSET_BITS'(1) : pos_q;
    consumed = 1'b0;
    flush_v  = 1'b0;
    flush_t  = '{kind: KIND_END, start: begin_rep, length: run_q, last: 1'b0};
    own_v    = 1'b0;
    own_t    = '{kind: KIND_ERROR, start: pos_rep, length: 16'd1, last: 1'b1};

    case (mode_q)
      MODE_COMMENT: begin
        if (byte_i != CH_NUL) consumed = 1'b1;
        if ((byte_i == CH_LF) || (byte_i == CH_NUL)) mode_d = MODE_IDLE;
      end
      MODE_IDENT: begin
        if (is_letter(byte_i) || is_digit(byte_i) || (byte_i == CH_UNDER)) begin
          if (run_q < 16'd5) prefix_d = {prefix_q[31:0], byte_i};
          run_d    = run_inc;
          consumed = 1'b1;
        end else begin
          flush_v      = 1'b1;
          flush_t.kind = word_kind;
          mode_d       = MODE_IDLE;
        end
      end
      MODE_NUMBER: begin
        if (is_digit(byte_i)) begin
          run_d    = run_inc;
          consumed = 1'b1;
        end else if ((byte_i == CH_DOT) && !dot_q) begin
          dot_d    = 1'b1;
          run_d    = run_inc;
          consumed = 1'b1;
        end else begin
          flush_v      = 1'b1;
          flush_t.kind = KIND_NUMBER;
          mode_d       = MODE_IDLE;
        end
      end
      MODE_OPER: begin
        flush_v = 1'b1;
        if (byte_i == CH_EQ) begin
          flush_t.kind   = oper_q + 5'd1;
          flush_t.length = 16'd2;
          consumed       = 1'b1;
        end else begin
          flush_t.kind   = oper_q;
          flush_t.length = 16'd1;
        end
        mode_d = MODE_IDLE;
      end
      default: mode_d = MODE_IDLE;
    endcase

    if (!consumed) begin
      if (byte_i == CH_NUL) begin
        // End of text: end token, then back to the reset state
        own_v        = 1'b1;
        own_t.kind   = KIND_END;
        own_t.length = 16'd0;
        mode_d       = MODE_IDLE;
        pos_d        = '0;
        begin_d      = '0;
        prefix_d     = '0;
        oper_d       = KIND_NONE;
        dot_d        = 1'b0;
        run_d        = '0;
      end else if ((byte_i == CH_TAB) || (byte_i == CH_LF) || (byte_i == CH_SPACE)) begin
        mode_d = MODE_IDLE;
      end else if (byte_i == CH_HASH) begin
        mode_d = MODE_COMMENT;
      end else if (is_letter(byte_i)) begin
        mode_d   = MODE_IDENT;
        begin_d  = pos_q;
        prefix_d = {32'd0, byte_i};
        run_d    = 16'd1;
      end else if (is_digit(byte_i)) begin
        mode_d  = MODE_NUMBER;
        begin_d = pos_q;
        dot_d   = 1'b0;
        run_d   = 16'd1;
      end else if (op != KIND_NONE) begin
        mode_d  = MODE_OPER;
        begin_d = pos_q;
        oper_d  = op;
      end else begin
        own_v = 1'b1;
        case (byte_i)
          CH_LPAR: own_t.kind = KIND_LPAREN;
          CH_RPAR: own_t.kind = KIND_RPAREN;
          CH_LBRC: own_t.kind = KIND_LBRACE;
          CH_RBRC: own_t.kind = KIND_RBRACE;
          CH_SEMI: own_t.kind = KIND_SEMI;
          default: own_t.kind = KIND_ERROR;
        endcase
      end
    end
  end

  // Order the results: flushed token first, last flag on the final one
  always_comb begin
    push_o.r0 = own_t;
    push_o.r1 = own_t;
    if (flush_v && own_v) begin
      push_o.cnt = 2'd2;
      push_o.r0  = flush_t;
    end else if (flush_v) begin
      push_o.cnt     = 2'd1;
      push_o.r0      = flush_t;
      push_o.r0.last = 1'b1;
    end else if (own_v) begin
      push_o.cnt = 2'd1;
    end else begin
      push_o.cnt = 2'd0;
    end
    if (!acc_i) push_o.cnt = 2'd0;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      pos_q  <= '0;
    end else if (acc_i) begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
    end
  end

  // Token context
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      begin_q  <= '0;
      prefix_q <= '0;
      oper_q   <= KIND_NONE;
      dot_q    <= 1'b0;
      run_q    <= '0;
    end else if (acc_i) begin
      begin_q  <= begin_d;
      prefix_q <= prefix_d;
      oper_q   <= oper_d;
      dot_q    <= dot_d;
      run_q    <= run_d;
    end
  end

endmodule

// ===== src/expression_language_tokenizer.sv =====
`timescale 1ns / 1ps
// Path: a token is written into the token queue when its byte is taken and
// leaves from the queue head. Throughput: one byte per cycle while the token
// queue has room for two tokens; a two-token byte takes two output handshakes.
// Reset: asynchronous, active low; scanner idle, offset 0, queue empty.
// ----------------------------------------------------------------------------
// expression_language_tokenizer: streaming lexical scanner
// Takes source text one byte per word and emits tokens (kind, start, length)
// through a four-entry queue that decouples the two stream sides.
// ----------------------------------------------------------------------------
module expression_language_tokenizer
  import elt_pkg::*;
#(
  parameter int OFFSET_BITS = OffsetBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] text_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [4:0] token_kind, [20:5] token_start,
                                        // [36:21] token_length, [39:37] zero
  output logic        m_axis_tlast_o    // last_of_run
);

  localparam int PtrBits = $clog2(QueueDepth);
  localparam int CntBits = $clog2(QueueDepth + 1);

  logic               in_acc, out_acc;
  push_t              push;
  tok_t               queue_q [QueueDepth];
  tok_t               head;
  logic [PtrBits-1:0] wr_q, rd_q;
  logic [CntBits-1:0] cnt_q;

  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc         = m_axis_tvalid_o && m_axis_tready_i;
  assign s_axis_tready_o = cnt_q <= CntBits'(QueueDepth - 2);

  elt_scan #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_scan (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .acc_i (in_acc),
    .byte_i(s_axis_tdata_i),
    .push_o(push)
  );

  // Token queue storage
  always_ff @(posedge clk_i) begin
    if (push.cnt != 2'd0) queue_q[wr_q] <= push.r0;
    if (push.cnt == 2'd2) queue_q[wr_q + PtrBits'(1)] <= push.r1;
  end

  // Queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PtrBits'(push.cnt);
      rd_q  <= rd_q + PtrBits'(out_acc);
      cnt_q <= cnt_q + CntBits'(push.cnt) - CntBits'(out_acc);
    end
  end

  // Output word
  assign head            = queue_q[rd_q];
  assign m_axis_tvalid_o = cnt_q != '0;
  assign m_axis_tdata_o  = {3'b000, head.length, head.start, head.kind};
  assign m_axis_tlast_o  = head.last;

`ifndef SYNTH
  // Fill count never passes the queue depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntBits'(QueueDepth))
    else $error("token queue overflow");

  // End of text always leaves a token queued
  a_end_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (s_axis_tdata_i == 8'h00)) |=> (cnt_q != '0))
    else $error("end of text produced no token");

  // End token closes the run of its byte
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (head.kind == KIND_END)) |-> head.last)
    else $error("end token without last flag");

  // Only the end token has zero length
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (head.kind != KIND_END)) |-> (head.length != 16'd0))
    else $error("zero-length token");
`endif

endmodule

// ===== bench/tb_expression_language_tokenizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_expression_language_tokenizer: self-checking bench for the tokenizer
// Streams directed and random source text into the scanner. A scanner model
// in the bench predicts every token (kind, start, length, last), and the
// output stream is checked word by word in order while both stream sides
// idle at random.
// ----------------------------------------------------------------------------
module tb_expression_language_tokenizer
  import elt_pkg::*;
;

  localparam int          RandomBytes  = 1500;   // token bytes in the random part
  localparam int          QuietLimit   = 2000;   // cycles without any handshake
  localparam int          ReportLimit  = 20;
  localparam logic [15:0] OffsetMax    = 16'hFFFF;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_COMMENT, SCAN_WORD, SCAN_NUMBER, SCAN_OPER
  } scan_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'h00;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  // Scanner model state
  scan_mode_e  scan_mode = SCAN_IDLE;
  logic [15:0] scan_pos = '0;
  logic [15:0] tok_begin = '0;
  logic [15:0] run_len = '0;
  logic [39:0] word_tail = '0;
  logic [4:0]  oper_kind = '0;
  logic        seen_dot = 1'b0;

  tok_t        expected_tokens[$];
  logic [7:0]  text_buf[$];
  string       word_list[12] = '{"if", "while", "loop", "print", "ihile", "whil",
                                 "whiles", "iff", "i", "loops", "prin", "Print"};

  int src_gap_max = 19;
  int sink_stall_max = 19;
  int sink_wait = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int tokens_checked = 0;
  int bytes_sent = 0;
  int texts_sent = 0;

  expression_language_tokenizer #(
    .OFFSET_BITS(OffsetBitsDef)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic tok_t token_of(logic [4:0] kind, logic [15:0] start,
                                    logic [15:0] len);
    tok_t t;
    t.kind   = kind;
    t.start  = start;
    t.length = len;
    t.last   = 1'b0;
    return t;
  endfunction

  function automatic logic letter_byte(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic digit_byte(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  // Base kind of a one-character operator, KIND_NONE when b is none
  function automatic logic [4:0] oper_of(logic [7:0] b);
    case (b)
      "+":     return KIND_PLUS;
      "-":     return KIND_MINUS;
      "*":     return KIND_STAR;
      "/":     return KIND_SLASH;
      "<":     return KIND_LT;
      ">":     return KIND_GT;
      "=":     return KIND_ASSIGN;
      "!":     return KIND_BANG;
      default: return KIND_NONE;
    endcase
  endfunction

  // Advance the scanner model by one byte and queue the tokens it yields
  task automatic predict_byte(input logic [7:0] b);
    tok_t        toks[2];
    int          n;
    logic        taken;
    logic        at_end;
    logic [15:0] here;
    logic [4:0]  kind;
    n      = 0;
    taken  = 1'b0;
    at_end = 1'b0;
    here   = scan_pos;

    // Continue or close the token in progress
    case (scan_mode)
      SCAN_COMMENT: begin
        if (b == "\n" || b == 8'h00) scan_mode = SCAN_IDLE;
        taken = (b != 8'h00);
      end
      SCAN_WORD: begin
        if (letter_byte(b) || digit_byte(b) || b == "_") begin
          if (run_len < 5) word_tail = {word_tail[31:0], b};
          if (run_len != OffsetMax) run_len++;
          taken = 1'b1;
        end else begin
          if (run_len == 2 && word_tail == KwIf) kind = KIND_IF;
          else if (run_len == 5 && word_tail == KwWhile) kind = KIND_WHILE;
          else if (run_len == 4 && word_tail == KwLoop) kind = KIND_LOOP;
          else if (run_len == 5 && word_tail == KwPrint) kind = KIND_PRINT;
          else kind = KIND_IDENT;
          toks[n++] = token_of(kind, tok_begin, run_len);
          scan_mode = SCAN_IDLE;
        end
      end
      SCAN_NUMBER: begin
        if (digit_byte(b) || (b == "." && !seen_dot)) begin
          if (b == ".") seen_dot = 1'b1;
          if (run_len != OffsetMax) run_len++;
          taken = 1'b1;
        end else begin
          toks[n++] = token_of(KIND_NUMBER, tok_begin, run_len);
          scan_mode = SCAN_IDLE;
        end
      end
      SCAN_OPER: begin
        if (b == "=") begin
          toks[n++] = token_of(oper_kind + 5'd1, tok_begin, 16'd2);
          taken = 1'b1;
        end else begin
          toks[n++] = token_of(oper_kind, tok_begin, 16'd1);
        end
        scan_mode = SCAN_IDLE;
      end
      default: scan_mode = SCAN_IDLE;
    endcase

    // Start a new token with this byte
    if (!taken) begin
      if (b == 8'h00) begin
        toks[n++] = token_of(KIND_END, here, 16'd0);
        at_end    = 1'b1;
        scan_mode = SCAN_IDLE;
        scan_pos  = '0;
        tok_begin = '0;
        run_len   = '0;
        word_tail = '0;
        oper_kind = '0;
        seen_dot  = 1'b0;
      end else if (b == "\t" || b == "\n" || b == " ") begin
        // blank
      end else if (b == "#") begin
        scan_mode = SCAN_COMMENT;
      end else if (letter_byte(b)) begin
        scan_mode = SCAN_WORD;
        tok_begin = here;
        word_tail = {32'd0, b};
        run_len   = 16'd1;
      end else if (digit_byte(b)) begin
        scan_mode = SCAN_NUMBER;
        tok_begin = here;
        seen_dot  = 1'b0;
        run_len   = 16'd1;
      end else if (oper_of(b) != KIND_NONE) begin
        scan_mode = SCAN_OPER;
        tok_begin = here;
        oper_kind = oper_of(b);
      end else begin
        case (b)
          "(":     kind = KIND_LPAREN;
          ")":     kind = KIND_RPAREN;
          "{":     kind = KIND_LBRACE;
          "}":     kind = KIND_RBRACE;
          ";":     kind = KIND_SEMI;
          default: kind = KIND_ERROR;
        endcase
        toks[n++] = token_of(kind, here, 16'd1);
      end
    end

    if (!at_end && scan_pos != OffsetMax) scan_pos++;
    if (n > 0) toks[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_tokens.push_back(toks[i]);
  endtask

  // Offer one byte after a random gap and hold it until taken
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = $urandom_range(src_gap_max, 0);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_byte(b);
    bytes_sent++;
  endtask

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endfunction

  task automatic send_text_buf();
    foreach (text_buf[i]) send_byte(text_buf[i]);
    text_buf.delete();
    texts_sent++;
  endtask

  // Stop offering bytes until every predicted token has come out
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (expected_tokens.size() != 0);
  endtask

  function automatic logic [7:0] pick_letter();
    return ($urandom_range(1, 0) ? 8'h61 : 8'h41) + 8'($urandom_range(25, 0));
  endfunction

  // A keyword, numbers, operators, parentheses, two-token bytes, bad characters, comment closed by end
  task automatic test_directed_tokens();
    src_gap_max    = 19;
    sink_stall_max = 19;
    add_text("print 1.2.3_+=!");
    text_buf.push_back(8'hFF);
    add_text("(1.)#c");
    text_buf.push_back(8'h00);
    send_text_buf();
  endtask

  // Random programs: mostly well-formed tokens, some noise bytes and comments
  task automatic test_random_texts();
    int    token_bytes;
    int    mark;
    string ops;
    string puncts;
    token_bytes = 0;
    ops         = "+-*/<>=!";
    puncts      = "(){};";
    while (token_bytes < RandomBytes) begin
      src_gap_max    = ($urandom_range(3, 0) == 0) ? 0 : 19;
      sink_stall_max = ($urandom_range(3, 0) == 0) ? 0 : 19;
      repeat ($urandom_range(12, 1)) begin
        mark = text_buf.size();
        case ($urandom_range(9, 0))
          0: add_text(word_list[$urandom_range(11, 0)]);
          1, 2: begin
            text_buf.push_back(pick_letter());
            repeat ($urandom_range(7, 0)) begin
              case ($urandom_range(2, 0))
                0:       text_buf.push_back(pick_letter());
                1:       text_buf.push_back(8'h30 + 8'($urandom_range(9, 0)));
                default: text_buf.push_back("_");
              endcase
            end
          end
          3, 4: begin
            repeat ($urandom_range(4, 1)) text_buf.push_back(8'h30 + 8'($urandom_range(9, 0)));
            if ($urandom_range(1, 0)) begin
              text_buf.push_back(".");
              repeat ($urandom_range(3, 0))
                text_buf.push_back(8'h30 + 8'($urandom_range(9, 0)));
              if ($urandom_range(5, 0) == 0) text_buf.push_back(".");
            end
          end
          5: begin
            text_buf.push_back(ops[$urandom_range(7, 0)]);
            if ($urandom_range(1, 0)) text_buf.push_back("=");
          end
          6: text_buf.push_back(puncts[$urandom_range(4, 0)]);
          7: begin
            text_buf.push_back("#");
            repeat ($urandom_range(6, 0)) text_buf.push_back(8'($urandom_range(126, 32)));
            if ($urandom_range(3, 0) != 0) text_buf.push_back("\n");
          end
          8: text_buf.push_back(8'($urandom_range(255, 1)));
          default: ;  // next token follows directly
        endcase
        token_bytes += text_buf.size() - mark;
        case ($urandom_range(3, 0))
          1:       text_buf.push_back(" ");
          2:       text_buf.push_back("\t");
          3:       text_buf.push_back("\n");
          default: ;
        endcase
      end
      if ($urandom_range(9, 0) != 0) text_buf.push_back(8'h00);
      send_text_buf();
      if (texts_sent % 8 == 0) wait_drained();
    end
  endtask

  // Output side: random stalls, in-order token check
  always @(posedge clk_i) begin : token_check
    tok_t got;
    tok_t want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got.kind   = m_axis_tdata_o[4:0];
      got.start  = m_axis_tdata_o[20:5];
      got.length = m_axis_tdata_o[36:21];
      got.last   = m_axis_tlast_o;
      if (expected_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("%0t: unexpected token kind %0d start %0d len %0d last %0b",
                   $time, got.kind, got.start, got.length, got.last);
      end else begin
        want = expected_tokens.pop_front();
        tokens_checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("%0t: token %0d expected kind %0d start %0d len %0d last %0b, got kind %0d start %0d len %0d last %0b",
                     $time, tokens_checked, want.kind, want.start, want.length, want.last,
                     got.kind, got.start, got.length, got.last);
        end
      end
      sink_wait = $urandom_range(sink_stall_max, 0);
    end else if (sink_wait > 0) begin
      sink_wait--;
    end
    m_axis_tready_i <= (sink_wait == 0);
  end

  // Watchdog on handshake activity
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == QuietLimit) begin
      $display("%0t: no word moved for %0d cycles, %0d tokens outstanding",
               $time, QuietLimit, expected_tokens.size());
      $display("expression_language_tokenizer regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_tokens();
    test_random_texts();
    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d bytes in %0d texts, %0d tokens checked, %0d mismatches.",
             bytes_sent, texts_sent, tokens_checked, mismatches);
    $display("Covered all token classes, two-token bytes and stalls on both sides.");
    if (mismatches == 0) begin
      $display("expression_language_tokenizer regression: pass");
    end else begin
      $display("expression_language_tokenizer regression: fail");
    end
    $finish;
  end

endmodule
